@@ sv/psg_pkg.sv @@
// Shared types, constants and lookup functions for the three-voice sound generator.
// No dependencies.
`default_nettype none
package psg_pkg;

  localparam int unsigned DivW = 22;
  localparam int unsigned StepW = 18;
  localparam logic [4:0] NoReg = 5'd31;

  localparam logic [1:0] CmdSel = 2'd0;
  localparam logic [1:0] CmdWr = 2'd1;
  localparam logic [1:0] CmdSmp = 2'd2;

  localparam logic [2:0] KNoise = 3'd3;
  localparam logic [2:0] KEnv = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CALC = 5'b00010,
    S_WAIT = 5'b00100,
    S_SMP  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  function automatic logic signed [15:0] level(input logic [4:0] idx);
    logic signed [15:0] r;
    unique case (idx)
      5'd0: r = 16'sd22;
      5'd1: r = 16'sd31;
      5'd2: r = 16'sd44;
      5'd3: r = 16'sd62;
      5'd4: r = 16'sd88;
      5'd5: r = 16'sd125;
      5'd6: r = 16'sd176;
      5'd7: r = 16'sd250;
      5'd8: r = 16'sd353;
      5'd9: r = 16'sd500;
      5'd10: r = 16'sd707;
      5'd11: r = 16'sd1000;
      5'd12: r = 16'sd1414;
      5'd13: r = 16'sd2000;
      5'd14: r = 16'sd2828;
      5'd15: r = 16'sd4000;
      5'd16: r = 16'sd5656;
      5'd17: r = 16'sd8000;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] env_level(input logic [3:0] shape, input logic [4:0] pos);
    logic [3:0] i;
    logic [3:0] r;
    i = pos[3:0];
    if (!pos[4]) begin
      r = shape[2] ? i : 4'd15 - i;
    end else begin
      unique case (shape)
        4'd11, 4'd13: r = 4'd15;
        4'd10, 4'd12: r = i;
        4'd8, 4'd14: r = 4'd15 - i;
        default: r = 4'd0;
      endcase
    end
    return r;
  endfunction

  function automatic logic env_repeat(input logic [3:0] shape);
    return (shape == 4'd8) || (shape == 4'd10) || (shape == 4'd12) || (shape == 4'd14);
  endfunction

endpackage
`default_nettype wire

@@ sv/psg_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
// Depends on psg_pkg.
`default_nettype none
module psg_div import psg_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DivW-1:0] dividend_i,
  input  wire logic [DivW-1:0] divisor_i,
  output logic                 done_o,
  output logic [DivW-1:0]      quotient_o
);
  localparam int unsigned CntW = $clog2(DivW + 1);

  logic            busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW:0]   rem_q, rem_d, rem_sh;
  logic [DivW-1:0] quo_q, quo_d, dvs_q, dvs_d;
  logic            ge;

  assign rem_sh = {rem_q[DivW-1:0], quo_q[DivW-1]};
  assign ge = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = CntW'(DivW);
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
      quo_d = {quo_q[DivW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

@@ sv/psg_three_voice_sound_generator_unit.sv @@
// Three-voice sound generator: register file, period sequencer and voice mixer.
// Select and most writes are taken without stalling. Tone and noise period writes
// recompute all four periods by up to 8 serial divisions; envelope ones up to 2.
// A sample beat mixes the three voices in turn, then loads the output register.
// One input beat at a time. Async active-low reset covers all state but nb_q, out_q.
// Depends on psg_pkg and psg_div.
`default_nettype none
module psg_three_voice_sound_generator_unit import psg_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_index_i,
  input  wire logic [DivW-1:0]    cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         cmd_i,
  input  wire logic [3:0]         reg_index_i,
  input  wire logic [7:0]         value_i,
  input  wire logic [2:0]         noise_bits_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      sample_out_o
);
  state_e state_q, state_d;
  logic [DivW-1:0]  chip_clk_q, chip_clk_d;
  logic [StepW-1:0] srate_q, srate_d;
  logic [4:0]  sel_q, sel_d;
  logic [11:0] tp_q [3], tp_d [3];
  logic [4:0]  np_q, np_d;
  logic [2:0]  ten_q, ten_d, nen_q, nen_d, use_q, use_d;
  logic [3:0]  vol_q [3], vol_d [3];
  logic [15:0] ep_q, ep_d;
  logic [3:0]  shape_q, shape_d;
  logic        built_q, built_d, rep_q, rep_d;
  logic [StepW-1:0] sp_q [4], sp_d [4];
  logic [StepW-1:0] esp_q, esp_d;
  logic [StepW-1:0] tc_q [3], tc_d [3];
  logic [2:0]  ph_q, ph_d;
  logic [StepW-1:0] ec_q, ec_d;
  logic [4:0]  pos_q, pos_d;
  logic [2:0]  k_q, k_d;
  logic        phase_q, phase_d;
  logic [1:0]  v_q, v_d;
  logic [2:0]  nb_q, nb_d;
  logic signed [15:0] acc_q, acc_d, out_q, out_d;
  logic        ov_q, ov_d;

  logic            div_start, div_done;
  logic [DivW-1:0] div_a, div_b, div_q;

  psg_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .done_o(div_done), .quotient_o(div_q)
  );

  logic [DivW-1:0] cur_div;
  logic            cur_zero;
  logic            accept;
  logic [StepW-1:0] tcn;
  logic            ten_v, nen_v, g, phb;
  logic [3:0]      vsel;
  logic [StepW-1:0] ecn;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    unique case (k_q)
      3'd0, 3'd1, 3'd2: cur_div = {7'd0, tp_q[k_q[1:0]], 3'd0};
      KNoise: cur_div = {14'd0, np_q, 3'd0};
      default: cur_div = {2'd0, ep_q, 4'd0};
    endcase
    cur_zero = cur_div == '0;
  end

  always_comb begin
    state_d = state_q;
    chip_clk_d = chip_clk_q;
    srate_d = srate_q;
    sel_d = sel_q;
    tp_d = tp_q;
    np_d = np_q;
    ten_d = ten_q;
    nen_d = nen_q;
    use_d = use_q;
    vol_d = vol_q;
    ep_d = ep_q;
    shape_d = shape_q;
    built_d = built_q;
    rep_d = rep_q;
    sp_d = sp_q;
    esp_d = esp_q;
    tc_d = tc_q;
    ph_d = ph_q;
    ec_d = ec_q;
    pos_d = pos_q;
    k_d = k_q;
    phase_d = phase_q;
    v_d = v_q;
    nb_d = nb_q;
    acc_d = acc_q;
    out_d = out_q;
    ov_d = ov_q && out_stall_i;
    div_start = 1'b0;
    div_a = cur_div;
    div_b = cur_div;
    tcn = '0;
    ten_v = 1'b0;
    nen_v = 1'b0;
    g = 1'b0;
    phb = 1'b0;
    vsel = '0;
    ecn = '0;

    if (cfg_we_i) begin
      if (cfg_index_i) srate_d = cfg_data_i[StepW-1:0];
      else chip_clk_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            CmdSel: sel_d = {1'b0, reg_index_i};
            CmdWr: begin
              if (sel_q <= 5'd5) begin
                if (!sel_q[0]) tp_d[sel_q[2:1]] = {tp_q[sel_q[2:1]][11:8], value_i};
                else tp_d[sel_q[2:1]] = {value_i[3:0], tp_q[sel_q[2:1]][7:0]};
                if (tp_d[sel_q[2:1]] != tp_q[sel_q[2:1]]) begin
                  ec_d = '0;
                  pos_d = '0;
                end
                k_d = 3'd0;
                state_d = S_CALC;
              end else if (sel_q == 5'd6) begin
                np_d = value_i[4:0];
                if (np_d != np_q) begin
                  ec_d = '0;
                  pos_d = '0;
                end
                k_d = 3'd0;
                state_d = S_CALC;
              end else if (sel_q == 5'd7) begin
                ten_d = ~value_i[2:0];
                nen_d = ~value_i[5:3];
              end else if (sel_q >= 5'd8 && sel_q <= 5'd10) begin
                vol_d[2'(sel_q - 5'd8)] = value_i[3:0];
                use_d[2'(sel_q - 5'd8)] = value_i[4];
                if (use_d != use_q) begin
                  ec_d = '0;
                  pos_d = '0;
                end
              end else if (sel_q == 5'd11 || sel_q == 5'd12) begin
                if (sel_q == 5'd11) ep_d = {ep_q[15:8], value_i};
                else ep_d = {value_i, ep_q[7:0]};
                if (ep_d != ep_q) begin
                  ec_d = '0;
                  pos_d = '0;
                end
                k_d = KEnv;
                state_d = S_CALC;
              end else if (sel_q == 5'd13) begin
                shape_d = value_i[3:0];
                if (shape_d != shape_q) begin
                  ec_d = '0;
                  pos_d = '0;
                end
                built_d = 1'b1;
                rep_d = env_repeat(shape_d);
              end
            end
            CmdSmp: begin
              nb_d = noise_bits_i;
              v_d = '0;
              acc_d = '0;
              state_d = S_SMP;
            end
            default: ;
          endcase
        end
      end
      S_CALC: begin
        if (cur_zero) begin
          if (k_q == KEnv) esp_d = '0;
          else sp_d[k_q[1:0]] = '0;
          if (k_q == KNoise || k_q == KEnv) state_d = S_IDLE;
          else k_d = k_q + 3'd1;
        end else begin
          div_start = 1'b1;
          div_a = chip_clk_q;
          div_b = cur_div;
          phase_d = 1'b0;
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (div_done) begin
          if (!phase_q && div_q != '0) begin
            div_start = 1'b1;
            div_a = {4'd0, srate_q};
            div_b = div_q;
            phase_d = 1'b1;
          end else begin
            if (k_q == KEnv) esp_d = phase_q ? div_q[StepW-1:0] : '0;
            else sp_d[k_q[1:0]] = phase_q ? div_q[StepW-1:0] : '0;
            if (k_q == KNoise || k_q == KEnv) state_d = S_IDLE;
            else begin
              k_d = k_q + 3'd1;
              state_d = S_CALC;
            end
          end
        end
      end
      S_SMP: begin
        tcn = tc_q[v_q] + 1'b1;
        phb = ph_q[v_q];
        if (tcn >= sp_q[v_q]) begin
          tcn = '0;
          phb = !phb;
        end
        tc_d[v_q] = tcn;
        ph_d[v_q] = phb;
        ten_v = ten_q[v_q];
        nen_v = nen_q[v_q];
        g = ten_v && sp_q[v_q] != '0 && phb;
        if (nen_v && sp_q[3] != '0) g = g ^ nb_q[v_q];
        if (ten_v || nen_v) begin
          vsel = vol_q[v_q];
          if (use_q[v_q]) begin
            vsel = built_q ? env_level(shape_q, pos_q) : 4'd0;
            ecn = ec_q + 1'b1;
            ec_d = ecn;
            if (ecn == esp_q) begin
              ec_d = '0;
              if (pos_q == 5'd31) pos_d = rep_q ? 5'd0 : 5'd31;
              else pos_d = pos_q + 5'd1;
            end
          end
          acc_d = acc_q + level(g ? {1'b0, vsel} + 5'd2 : 5'd2) - level({1'b0, vsel});
        end
        if (v_q == 2'd2) state_d = S_OUT;
        else v_d = v_q + 2'd1;
      end
      S_OUT: begin
        if (!ov_d) begin
          out_d = acc_q;
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      chip_clk_q <= DivW'(1773400);
      srate_q <= StepW'(44100);
      sel_q <= NoReg;
      tp_q <= '{default: '0};
      np_q <= '0;
      ten_q <= '0;
      nen_q <= '0;
      use_q <= '0;
      vol_q <= '{default: '0};
      ep_q <= '0;
      shape_q <= '0;
      built_q <= 1'b0;
      rep_q <= 1'b0;
      sp_q <= '{default: '0};
      esp_q <= '0;
      tc_q <= '{default: '0};
      ph_q <= '0;
      ec_q <= '0;
      pos_q <= '0;
      k_q <= '0;
      phase_q <= 1'b0;
      v_q <= '0;
      acc_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      chip_clk_q <= chip_clk_d;
      srate_q <= srate_d;
      sel_q <= sel_d;
      tp_q <= tp_d;
      np_q <= np_d;
      ten_q <= ten_d;
      nen_q <= nen_d;
      use_q <= use_d;
      vol_q <= vol_d;
      ep_q <= ep_d;
      shape_q <= shape_d;
      built_q <= built_d;
      rep_q <= rep_d;
      sp_q <= sp_d;
      esp_q <= esp_d;
      tc_q <= tc_d;
      ph_q <= ph_d;
      ec_q <= ec_d;
      pos_q <= pos_d;
      k_q <= k_d;
      phase_q <= phase_d;
      v_q <= v_d;
      acc_q <= acc_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nb_q <= nb_d;
    out_q <= out_d;
  end

  assign out_valid_o = ov_q;
  assign sample_out_o = out_q;
endmodule
`default_nettype wire
